@@ hdl/sipb_pkg.sv @@
// Shared types, packet constants and byte/CRC functions of the SCTP INIT probe builder.
// Used by every module of the block; depends on nothing else.
package sipb_pkg;

	localparam int PKT_LEN = 48;
	localparam int IDX_W = 6;
	localparam int QCNT_W = 2;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [7:0]  CHUNK_INIT       = 8'h01;
	localparam logic [15:0] INIT_CHUNK_LEN   = 16'd36;
	localparam logic [15:0] PARAM_ADDR_TYPES = 16'h000C;
	localparam logic [15:0] PARAM_ADDR_LEN   = 16'd6;
	localparam logic [15:0] ADDR_TYPE_IPV4   = 16'h0005;
	localparam logic [15:0] PARAM_ECN        = 16'h8000;
	localparam logic [15:0] PARAM_FWD_TSN    = 16'hC000;
	localparam logic [15:0] PARAM_EMPTY_LEN  = 16'd4;

	localparam logic [31:0] RWND_RESET    = 32'd106496;
	localparam logic [15:0] OUT_STR_RESET = 16'd10;
	localparam logic [15:0] IN_STR_RESET  = 16'd65535;

	localparam logic [1:0] REG_RECEIVE_WINDOW   = 2'd0;
	localparam logic [1:0] REG_OUTBOUND_STREAMS = 2'd1;
	localparam logic [1:0] REG_INBOUND_STREAMS  = 2'd2;

	typedef struct packed {
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] init_tag;
		logic [31:0] first_tsn;
	} req_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] byte_index;
		logic             last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] receive_window;
		logic [15:0] outbound_streams;
		logic [15:0] inbound_streams;
	} cfg_t;

	typedef struct packed {
		req_t        probe;
		logic [31:0] crc;
	} qent_t;

	// One CRC32c step over a byte, LSB first.
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Byte at position idx of the packet; crc fills the checksum bytes.
	function automatic logic [7:0] pkt_byte(input req_t p, input cfg_t cfg,
			input logic [31:0] crc, input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			6'd0:  b = p.source_port[15:8];
			6'd1:  b = p.source_port[7:0];
			6'd2:  b = p.dest_port[15:8];
			6'd3:  b = p.dest_port[7:0];
			6'd8:  b = crc[7:0];
			6'd9:  b = crc[15:8];
			6'd10: b = crc[23:16];
			6'd11: b = crc[31:24];
			6'd12: b = CHUNK_INIT;
			6'd14: b = INIT_CHUNK_LEN[15:8];
			6'd15: b = INIT_CHUNK_LEN[7:0];
			6'd16: b = p.init_tag[31:24];
			6'd17: b = p.init_tag[23:16];
			6'd18: b = p.init_tag[15:8];
			6'd19: b = p.init_tag[7:0];
			6'd20: b = cfg.receive_window[31:24];
			6'd21: b = cfg.receive_window[23:16];
			6'd22: b = cfg.receive_window[15:8];
			6'd23: b = cfg.receive_window[7:0];
			6'd24: b = cfg.outbound_streams[15:8];
			6'd25: b = cfg.outbound_streams[7:0];
			6'd26: b = cfg.inbound_streams[15:8];
			6'd27: b = cfg.inbound_streams[7:0];
			6'd28: b = p.first_tsn[31:24];
			6'd29: b = p.first_tsn[23:16];
			6'd30: b = p.first_tsn[15:8];
			6'd31: b = p.first_tsn[7:0];
			6'd32: b = PARAM_ADDR_TYPES[15:8];
			6'd33: b = PARAM_ADDR_TYPES[7:0];
			6'd34: b = PARAM_ADDR_LEN[15:8];
			6'd35: b = PARAM_ADDR_LEN[7:0];
			6'd36: b = ADDR_TYPE_IPV4[15:8];
			6'd37: b = ADDR_TYPE_IPV4[7:0];
			6'd40: b = PARAM_ECN[15:8];
			6'd41: b = PARAM_ECN[7:0];
			6'd42: b = PARAM_EMPTY_LEN[15:8];
			6'd43: b = PARAM_EMPTY_LEN[7:0];
			6'd44: b = PARAM_FWD_TSN[15:8];
			6'd45: b = PARAM_FWD_TSN[7:0];
			6'd46: b = PARAM_EMPTY_LEN[15:8];
			6'd47: b = PARAM_EMPTY_LEN[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ hdl/sipb_front.sv @@
// Front end: accepts a probe request and runs the CRC32c over its packet, one byte a cycle.
// Depends on sipb_pkg; pushes finished requests with their checksum into sipb_queue.
module sipb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sipb_pkg::req_t  req,
	input  sipb_pkg::cfg_t  cfg,
	input  logic            q_full,
	output logic            q_push,
	output sipb_pkg::qent_t q_wdata
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CALC = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t                    state_q;
	sipb_pkg::req_t             item_q;
	logic [sipb_pkg::IDX_W-1:0] cnt_q;
	logic [31:0]                crc_q;

	logic        last_calc;
	logic [31:0] crc_next;
	logic        accept;

	assign crc_next  = sipb_pkg::crc32c_byte(crc_q,
		sipb_pkg::pkt_byte(item_q, cfg, 32'h0, cnt_q));
	assign last_calc = (state_q == F_CALC) && (cnt_q == sipb_pkg::IDX_W'(sipb_pkg::PKT_LEN - 1));

	// A new request can enter in the same cycle the previous one leaves for the queue.
	always_comb begin
		q_push  = 1'b0;
		q_wdata = '{probe: item_q, crc: crc_q};
		case (state_q)
			F_CALC: begin
				q_push  = last_calc && !q_full;
				q_wdata = '{probe: item_q, crc: ~crc_next};
			end
			F_PUSH: q_push = !q_full;
			default: q_push = 1'b0;
		endcase
	end

	assign req_stall = !((state_q == F_IDLE) || q_push);
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (accept) state_q <= F_CALC;
				F_CALC: begin
					if (last_calc) begin
						if (q_push) state_q <= accept ? F_CALC : F_IDLE;
						else state_q <= F_PUSH;
					end
				end
				F_PUSH: if (q_push) state_q <= accept ? F_CALC : F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
			cnt_q  <= '0;
			crc_q  <= sipb_pkg::CRC_INIT;
		end else if (state_q == F_CALC) begin
			cnt_q <= cnt_q + 1'b1;
			crc_q <= last_calc ? ~crc_next : crc_next;
		end
	end

endmodule

@@ hdl/sipb_queue.sv @@
// Two-entry queue between the checksum front end and the byte emitter.
// Depends on sipb_pkg for the entry type.
module sipb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sipb_pkg::qent_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output sipb_pkg::qent_t rdata
);

	sipb_pkg::qent_t             mem_q [2];
	logic                        wptr_q;
	logic                        rptr_q;
	logic [sipb_pkg::QCNT_W-1:0] count_q;

	assign full     = (count_q == sipb_pkg::QCNT_W'(2));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue popped while empty");

endmodule

@@ hdl/sipb_back.sv @@
// Back end: takes a request with its checksum from the queue and emits its 48 bytes.
// Depends on sipb_pkg for the packet byte function and types.
module sipb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  sipb_pkg::qent_t q_rdata,
	output logic            q_pop,
	input  sipb_pkg::cfg_t  cfg,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output sipb_pkg::rsp_t  rsp
);

	logic                       active_q;
	sipb_pkg::qent_t            cur_q;
	logic [sipb_pkg::IDX_W-1:0] idx_q;

	logic taken;
	logic at_end;

	assign at_end    = (idx_q == sipb_pkg::IDX_W'(sipb_pkg::PKT_LEN - 1));
	assign taken     = active_q && !rsp_stall;
	assign q_pop     = q_nonempty && (!active_q || (taken && at_end));
	assign rsp_valid = active_q;
	assign rsp       = '{data_byte:  sipb_pkg::pkt_byte(cur_q.probe, cfg, cur_q.crc, idx_q),
	                     byte_index: idx_q,
	                     last:       at_end};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (q_pop) begin
			active_q <= 1'b1;
		end else if (taken && at_end) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rdata;
			idx_q <= '0;
		end else if (taken) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_stall && !rsp.last) |=>
			(rsp_valid && rsp.byte_index == $past(rsp.byte_index) + 1'b1))
		else $error("byte index did not advance by one");

	a_packet_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (rsp_valid && rsp.byte_index == '0))
		else $error("new packet did not start at byte zero");

endmodule

@@ hdl/sctp_init_probe_builder.sv @@
// Top level of the SCTP INIT probe builder: configuration registers and the three stages.
// Depends on sipb_pkg, sipb_front, sipb_queue and sipb_back.

// Each request (source port, destination port, initiate tag, initial TSN) turns into
// the 48-byte SCTP part of an INIT probe, sent one byte per transfer on the rsp channel
// with its position and a last flag on byte 47. The CRC32c in bytes 8..11 covers the
// whole packet, so the front end first walks all 48 bytes through a byte-wide CRC
// step, one byte a cycle, and then hands the request and its checksum to a two-entry
// queue. The back end drains the queue and sends one byte a cycle while rsp
// is not stalled. Front and back overlap, so with no stall on rsp the block
// emits a byte every cycle and takes the next request while the previous packet
// is still being sent. The CRC byte step and the byte rate of rsp both limit the
// request rate. Configuration registers sit on an APB port at byte addresses
// 0 (receive window), 4 (outbound streams) and 8 (inbound streams); they are read
// live by both stages and must be written only while no probe is in flight.
module sctp_init_probe_builder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sipb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sipb_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	sipb_pkg::cfg_t  cfg_q;
	logic            wr_en;
	logic [1:0]      reg_sel;

	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_nonempty;
	sipb_pkg::qent_t q_wdata;
	sipb_pkg::qent_t q_rdata;

	// Register index is the word address; the unused fourth slot ignores writes
	// and reads as zero.
	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.receive_window   <= sipb_pkg::RWND_RESET;
			cfg_q.outbound_streams <= sipb_pkg::OUT_STR_RESET;
			cfg_q.inbound_streams  <= sipb_pkg::IN_STR_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				sipb_pkg::REG_RECEIVE_WINDOW:   cfg_q.receive_window   <= pwdata;
				sipb_pkg::REG_OUTBOUND_STREAMS: cfg_q.outbound_streams <= pwdata[15:0];
				sipb_pkg::REG_INBOUND_STREAMS:  cfg_q.inbound_streams  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			sipb_pkg::REG_RECEIVE_WINDOW:   prdata = cfg_q.receive_window;
			sipb_pkg::REG_OUTBOUND_STREAMS: prdata = {16'h0, cfg_q.outbound_streams};
			sipb_pkg::REG_INBOUND_STREAMS:  prdata = {16'h0, cfg_q.inbound_streams};
			default:                        prdata = 32'h0;
		endcase
	end

	// The front end computes the checksum for one request while the back end is
	// still sending the previous packet.
	sipb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	sipb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	// The back end holds the current packet and byte index in registers, so the
	// byte on rsp stays put while rsp is stalled.
	sipb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.cfg        (cfg_q),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

@@ bench/tb_sctp_init_probe_builder.sv @@
// Self-checking testbench for sctp_init_probe_builder: directed and random INIT probes.
// Depends on sipb_pkg for the port types and packet constants, and on the block's RTL.
module tb_sctp_init_probe_builder;
	timeunit 1ns;
	timeprecision 1ps;

	// The run stops here even if the block hangs. The limit leaves room for the slowest
	// correct run: 245 probes of 48 bytes, each byte followed by the longest receiver stall.
	localparam int CYCLE_LIMIT = 600_000;
	// Settling time at the end of the run, longer than a request takes to reach its first byte.
	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_PROBES = 46;

	// Register index past the end of the map; a write there must change nothing.
	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	sipb_pkg::req_t req = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	sipb_pkg::rsp_t rsp;
	logic           psel = 1'b0;
	logic           penable = 1'b0;
	logic           pwrite = 1'b0;
	logic [3:0]     paddr = '0;
	logic [31:0]    pwdata = '0;
	logic [31:0]    prdata;
	logic           pready;

	// Our copy of the configuration registers, as the block should hold them.
	sipb_pkg::cfg_t live_cfg;
	// Bytes that the block still owes us, oldest first.
	sipb_pkg::rsp_t expected_bytes [$];
	int   mismatches = 0;
	int   cycles = 0;
	// When set, neither side inserts idle cycles, so the block runs at full rate.
	bit   quiet = 1'b0;
	int   rsp_hold = 0;

	sctp_init_probe_builder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: a run that takes this long has hung somewhere.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Number of idle cycles a side puts in front of its next transfer.
	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	// Forms the whole 48-byte probe in wire order, byte 0 in the top bits, and
	// fills in the CRC32c. The checksum is run over the packet with bytes 8..11
	// still zero and then stored least significant byte first.
	function automatic logic [383:0] probe_bytes(input sipb_pkg::req_t p,
			input sipb_pkg::cfg_t c);
		logic [383:0] pkt;
		logic [31:0]  crc;
		int           k;
		int           b;
		pkt = {p.source_port, p.dest_port, 32'h0, 32'h0,
			sipb_pkg::CHUNK_INIT, 8'h00, sipb_pkg::INIT_CHUNK_LEN, p.init_tag,
			c.receive_window, c.outbound_streams, c.inbound_streams, p.first_tsn,
			sipb_pkg::PARAM_ADDR_TYPES, sipb_pkg::PARAM_ADDR_LEN,
			sipb_pkg::ADDR_TYPE_IPV4, 16'h0000,
			sipb_pkg::PARAM_ECN, sipb_pkg::PARAM_EMPTY_LEN,
			sipb_pkg::PARAM_FWD_TSN, sipb_pkg::PARAM_EMPTY_LEN};
		crc = 32'hFFFF_FFFF;
		for (k = 0; k < sipb_pkg::PKT_LEN; k++) begin
			crc = crc ^ {24'h0, pkt[383 - 8 * k -: 8]};
			for (b = 0; b < 8; b++) begin
				crc = crc[0] ? ((crc >> 1) ^ 32'h82F6_3B78) : (crc >> 1);
			end
		end
		crc = ~crc;
		pkt[319 -: 32] = {crc[7:0], crc[15:8], crc[23:16], crc[31:24]};
		return pkt;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
	endtask

	// Receiver: checks every result transfer against the oldest expected byte and
	// then holds stall high for a freshly drawn number of cycles. The countdown
	// runs on whether or not a byte is waiting, so stalls land on every phase.
	always @(posedge clk) begin
		sipb_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("byte with nothing expected", 32'(rsp.data_byte), 32'h0);
			end else begin
				want = expected_bytes.pop_front();
				if (rsp.data_byte !== want.data_byte)
					report_mismatch("data_byte", 32'(rsp.data_byte), 32'(want.data_byte));
				if (rsp.byte_index !== want.byte_index)
					report_mismatch("byte_index", 32'(rsp.byte_index),
						32'(want.byte_index));
				if (rsp.last !== want.last)
					report_mismatch("last", 32'(rsp.last), 32'(want.last));
			end
			rsp_hold = draw_wait();
		end else if (rsp_hold > 0) begin
			rsp_hold--;
		end
		rsp_stall <= (rsp_hold != 0);
	end

	// Sends one probe request and, once the transfer is taken, queues the 48
	// bytes it must produce. Valid stays high when the next probe follows with
	// no gap, so it is never lowered and raised within one step.
	task automatic send_probe(input sipb_pkg::req_t p);
		logic [383:0]   pkt;
		sipb_pkg::rsp_t one;
		int             gap;
		int             k;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= p;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pkt = probe_bytes(p, live_cfg);
		for (k = 0; k < sipb_pkg::PKT_LEN; k++) begin
			one.data_byte = pkt[383 - 8 * k -: 8];
			one.byte_index = k[sipb_pkg::IDX_W-1:0];
			one.last = (k == sipb_pkg::PKT_LEN - 1);
			expected_bytes.push_back(one);
		end
	endtask

	// Ends a batch of requests and waits until every byte of it has come out.
	// Each probe always yields bytes, so an empty queue means the block is idle.
	task automatic drain_probes();
		req_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready. Only called while
	// the block is idle. The 16-bit registers keep the low half of the data.
	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			sipb_pkg::REG_RECEIVE_WINDOW:   live_cfg.receive_window = value;
			sipb_pkg::REG_OUTBOUND_STREAMS: live_cfg.outbound_streams = value[15:0];
			sipb_pkg::REG_INBOUND_STREAMS:  live_cfg.inbound_streams = value[15:0];
			default: ;
		endcase
	endtask

	function automatic sipb_pkg::req_t random_probe();
		sipb_pkg::req_t p;
		p.source_port = 16'($urandom_range(0, 65535));
		p.dest_port = 16'($urandom_range(0, 65535));
		p.init_tag = $urandom();
		p.first_tsn = $urandom();
		return p;
	endfunction

	// Probes under the reset configuration, with the request fields at their
	// extremes and in alternating bit patterns.
	task automatic test_reset_config();
		send_probe('0);
		send_probe('1);
		send_probe({16'h0001, 16'h8000, 32'h0000_0001, 32'h8000_0000});
		send_probe({16'hA5A5, 16'h5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A});
		send_probe({16'h5A5A, 16'hA5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5});
		drain_probes();
	endtask

	// Every register at zero, then at its maximum, then written with junk in the
	// bits above a 16-bit register's width, and finally a write to an index
	// outside the map, which must leave the registers alone.
	task automatic test_config_extremes();
		write_reg(sipb_pkg::REG_RECEIVE_WINDOW, 32'h0);
		write_reg(sipb_pkg::REG_OUTBOUND_STREAMS, 32'h0);
		write_reg(sipb_pkg::REG_INBOUND_STREAMS, 32'h0);
		send_probe('0);
		send_probe('1);
		send_probe(random_probe());
		drain_probes();

		write_reg(sipb_pkg::REG_RECEIVE_WINDOW, 32'hFFFF_FFFF);
		write_reg(sipb_pkg::REG_OUTBOUND_STREAMS, 32'hFFFF_FFFF);
		write_reg(sipb_pkg::REG_INBOUND_STREAMS, 32'hFFFF_FFFF);
		send_probe('0);
		send_probe('1);
		send_probe(random_probe());
		drain_probes();

		write_reg(sipb_pkg::REG_OUTBOUND_STREAMS, 32'hABCD_1234);
		write_reg(sipb_pkg::REG_INBOUND_STREAMS, 32'h5432_00FE);
		send_probe(random_probe());
		send_probe(random_probe());
		drain_probes();

		write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
		send_probe(random_probe());
		send_probe(random_probe());
		drain_probes();
	endtask

	// Random probes in phases, with a new configuration between phases. Each
	// phase has a stretch with no idling on either side so the block also runs
	// back to back at its full byte rate.
	task automatic test_random_probes();
		int phase;
		int i;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				1: begin
					write_reg(sipb_pkg::REG_RECEIVE_WINDOW, 32'hFFFF_FFFF);
					write_reg(sipb_pkg::REG_OUTBOUND_STREAMS, 32'h0000_FFFF);
					write_reg(sipb_pkg::REG_INBOUND_STREAMS, 32'h0);
				end
				3: begin
					write_reg(sipb_pkg::REG_RECEIVE_WINDOW, sipb_pkg::RWND_RESET);
					write_reg(sipb_pkg::REG_OUTBOUND_STREAMS,
						{16'h0, sipb_pkg::OUT_STR_RESET});
					write_reg(sipb_pkg::REG_INBOUND_STREAMS,
						{16'h0, sipb_pkg::IN_STR_RESET});
				end
				default: begin
					write_reg(sipb_pkg::REG_RECEIVE_WINDOW, $urandom());
					write_reg(sipb_pkg::REG_OUTBOUND_STREAMS, $urandom());
					write_reg(sipb_pkg::REG_INBOUND_STREAMS, $urandom());
				end
			endcase
			for (i = 0; i < PHASE_PROBES; i++) begin
				quiet = (i >= 20 && i < 32);
				send_probe(random_probe());
			end
			quiet = 1'b0;
			drain_probes();
		end
	endtask

	initial begin
		live_cfg.receive_window = sipb_pkg::RWND_RESET;
		live_cfg.outbound_streams = sipb_pkg::OUT_STR_RESET;
		live_cfg.inbound_streams = sipb_pkg::IN_STR_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_config_extremes();
		test_random_probes();

		// Anything the block emits after the last expected byte counts as extra.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
